/* design/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg - shared types and constants of the token sampler
// Sizes, opcodes, register indexes, command/status bundles, exp table builder.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int VOCAB           = 32768;
  localparam int MAX_K           = 64;
  localparam int EXP_TABLE_DEPTH = 1024;

  localparam int TOK_W   = 15;
  localparam int LOGIT_W = 16;
  localparam int FRAC_W  = 16;
  localparam int KEEP_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ADDR_W = $clog2(VOCAB);
  localparam int CNT_W  = $clog2(MAX_K + 1);
  localparam int EXP_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int WT_W   = 17;
  localparam int SUM_W  = WT_W + CNT_W;
  localparam int PROD_W = SUM_W + 16;

  // opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_DRAW  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUCLEUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_T   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_P   = 2'd3;

  // draw pass selection
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_TOTAL = 2'd1;
  localparam logic [1:0] MODE_NUCL  = 2'd2;
  localparam logic [1:0] MODE_PICK  = 2'd3;

  typedef struct packed {
    logic       acc;
    logic       clr_en;
    logic       mul_en;
    logic       mul_pen;
    logic       sat_en;
    logic       sat_drop16;
    logic       ins_en;
    logic       dr_start;
    logic       pass_start;
    logic       rot_en;
    logic [1:0] acc_mode;
    logic       thr_en;
    logic       rth_en;
    logic       fin_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mark_p;
    logic mark_g;
    logic n_zero;
    logic rot_last;
    logic out_busy;
  } sts_t;

  typedef logic [WT_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // exp(-i/64) in Q1.16, built by the fixed-point recurrence
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    r;
    logic [63:0] v;
    logic [63:0] t;
    v = 64'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      if (i > 0) v = (v * 64'd4228380000 + (64'd1 << 31)) >> 32;
      t = (v + 64'd32768) >> 16;
      r[i] = t[WT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/tts_dp.sv */
// ----------------------------------------------------------------------------
// tts_dp - sampler datapath
// Mark memories, scaling multiplier, candidate cells, draw accumulators.
// ----------------------------------------------------------------------------
module tts_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tts_pkg::cmd_t                 cmd_i,
  output tts_pkg::sts_t                 sts_o,
  input  logic [1:0]                    opcode_i,
  input  logic [tts_pkg::TOK_W-1:0]     token_id_i,
  input  logic signed [tts_pkg::LOGIT_W-1:0] logit_value_i,
  input  logic [tts_pkg::FRAC_W-1:0]    random_fraction_i,
  input  logic                          cfg_valid_i,
  input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tts_pkg::TOK_W-1:0]     chosen_token_o,
  output logic                          status_o
);
  import tts_pkg::*;

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // configuration
  logic [KEEP_W-1:0] keep_q;
  logic [15:0]       nucl_q, inv_t_q, inv_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q  <= KEEP_W'(40);
      nucl_q  <= 16'd62259;
      inv_t_q <= 16'd5851;
      inv_p_q <= 16'd59578;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KEEP:    keep_q  <= cfg_data_i[KEEP_W-1:0];
        REG_NUCLEUS: nucl_q  <= cfg_data_i;
        REG_INV_T:   inv_t_q <= cfg_data_i;
        REG_INV_P:   inv_p_q <= cfg_data_i;
        default:     keep_q  <= keep_q;
      endcase
    end
  end

  // mark memories
  logic              prompt_mem [VOCAB];
  logic              gen_mem    [VOCAB];
  logic [ADDR_W-1:0] clr_addr_q;
  logic              p_rd_q, g_rd_q, vocab_q;
  logic              in_vocab, mark_wr, mark_rd, gen_wr;
  logic [ADDR_W-1:0] tok_addr, pick_addr;
  logic [TOK_W-1:0]  pick_q;
  logic              empty_q;

  assign in_vocab  = 32'(token_id_i) < VOCAB;
  assign tok_addr  = ADDR_W'(token_id_i);
  assign pick_addr = ADDR_W'(pick_q);
  assign mark_wr   = cmd_i.acc && (opcode_i == OP_MARK) && in_vocab;
  assign mark_rd   = cmd_i.acc && (opcode_i == OP_LOAD);
  assign gen_wr    = cmd_i.fin_en && !empty_q && (32'(pick_q) < VOCAB);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      prompt_mem[clr_addr_q] <= 1'b0;
    end else if (mark_wr) begin
      prompt_mem[tok_addr] <= 1'b1;
    end
    if (mark_rd) begin
      p_rd_q <= prompt_mem[tok_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      gen_mem[clr_addr_q] <= 1'b0;
    end else if (gen_wr) begin
      gen_mem[pick_addr] <= 1'b1;
    end
    if (mark_rd) begin
      g_rd_q <= gen_mem[tok_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  // scaling: sign and magnitude, one multiply then round/saturate
  logic             neg_q;
  logic [15:0]      mag_q;
  logic [TOK_W-1:0] tok_q;
  logic [15:0]      rnd_q;
  logic [31:0]      prod_q;
  logic [32:0]      rsum, rshift;
  logic [15:0]      lim;
  logic signed [15:0] s_new;

  assign rsum   = {1'b0, prod_q} + (cmd_i.sat_drop16 ? 33'h8000 : 33'h800);
  assign rshift = cmd_i.sat_drop16 ? (rsum >> 16) : (rsum >> 12);
  assign lim    = neg_q ? 16'd32768 : 16'd32767;
  assign s_new  = neg_q ? -$signed(mag_q) : $signed(mag_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      tok_q   <= token_id_i;
      neg_q   <= logit_value_i[LOGIT_W-1];
      mag_q   <= logit_value_i[LOGIT_W-1] ? 16'(-logit_value_i) : 16'(logit_value_i);
      rnd_q   <= random_fraction_i;
      vocab_q <= in_vocab;
    end else if (cmd_i.sat_en) begin
      mag_q <= (rshift > {17'd0, lim}) ? lim : rshift[15:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= mag_q * (cmd_i.mul_pen ? inv_p_q : inv_t_q);
    end
  end

  // candidate cells
  logic [TOK_W-1:0]   ids_q [MAX_K];
  logic signed [15:0] sc_q  [MAX_K];
  logic [CNT_W-1:0]   fill_q, k_eff, n_cur, last;
  logic [MAX_K-1:0]   b, bprev;

  always_comb begin
    if (keep_q == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(keep_q) > MAX_K) begin
      k_eff = CNT_W'(MAX_K);
    end else begin
      k_eff = CNT_W'(keep_q);
    end
    n_cur = (fill_q < k_eff) ? fill_q : k_eff;
    last  = (n_cur < k_eff) ? n_cur : k_eff - 1'b1;
    for (int j = 0; j < MAX_K; j++) begin
      b[j] = (CNT_W'(j) >= n_cur) || (s_new > sc_q[j]) ||
             ((s_new == sc_q[j]) && (tok_q < ids_q[j]));
    end
    bprev = b << 1;
  end

  // draw state
  logic signed [15:0] top_q;
  logic [CNT_W-1:0]   n_q, m_q, cnt_q, j_q, lim_cnt;
  logic               iv_q, found_q, oor_q;
  logic [TOK_W-1:0]   pid_q;
  logic [WT_W-1:0]    rom_q, wt;
  logic [SUM_W-1:0]   cum_q, ksum_q, cum_nx;
  logic [PROD_W-1:0]  thr_q, rth_q, cum_sh, thr_prod, rth_prod;
  logic signed [16:0] diff;
  logic [13:0]        idx;

  assign diff     = 17'(top_q) - 17'(sc_q[0]);
  assign idx      = diff[16] ? '0 : diff[15:2];
  assign lim_cnt  = (cmd_i.acc_mode == MODE_PICK) ? m_q : n_q;
  assign wt       = oor_q ? '0 : rom_q;
  assign cum_nx   = cum_q + SUM_W'(wt);
  assign cum_sh   = {cum_nx, 16'd0};
  assign thr_prod = nucl_q * cum_q;
  assign rth_prod = rnd_q * ksum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_en) begin
      for (int j = 0; j < MAX_K; j++) begin
        if (CNT_W'(j) < k_eff) begin
          if (b[j] && !bprev[j]) begin
            ids_q[j] <= tok_q;
            sc_q[j]  <= s_new;
          end else if (b[j] && bprev[j] && (CNT_W'(j) <= last)) begin
            ids_q[j] <= ids_q[(j + MAX_K - 1) % MAX_K];
            sc_q[j]  <= sc_q[(j + MAX_K - 1) % MAX_K];
          end
        end
      end
    end else if (cmd_i.rot_en) begin
      for (int j = 0; j < MAX_K; j++) begin
        ids_q[j] <= ids_q[(j + 1) % MAX_K];
        sc_q[j]  <= sc_q[(j + 1) % MAX_K];
      end
    end
    if (cmd_i.dr_start) begin
      top_q <= sc_q[0];
      n_q   <= n_cur;
    end
    if (cmd_i.rot_en) begin
      j_q   <= cnt_q;
      pid_q <= ids_q[0];
      rom_q <= EXP_ROM[idx[EXP_W-1:0]];
      oor_q <= 32'(idx) >= EXP_TABLE_DEPTH;
    end
    if (cmd_i.thr_en) begin
      thr_q <= thr_prod;
    end
    if (cmd_i.rth_en) begin
      rth_q <= rth_prod;
    end
    if (iv_q && !found_q) begin
      if (cmd_i.acc_mode == MODE_NUCL) begin
        ksum_q <= cum_nx;
      end
      if (cmd_i.acc_mode == MODE_PICK) begin
        pick_q <= pid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      cnt_q   <= '0;
      iv_q    <= 1'b0;
      found_q <= 1'b0;
      cum_q   <= '0;
      m_q     <= '0;
      empty_q <= 1'b1;
    end else begin
      if (cmd_i.ins_en) begin
        fill_q <= (n_cur < k_eff) ? n_cur + 1'b1 : k_eff;
      end else if (cmd_i.dr_start) begin
        fill_q  <= '0;
        m_q     <= n_cur;
        empty_q <= (n_cur == '0);
      end
      iv_q <= cmd_i.rot_en && (cnt_q < lim_cnt);
      if (cmd_i.pass_start) begin
        cnt_q   <= '0;
        cum_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.rot_en) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (iv_q && !found_q) begin
          cum_q <= cum_nx;
          if ((cmd_i.acc_mode == MODE_NUCL) && (cum_sh >= thr_q)) begin
            found_q <= 1'b1;
            m_q     <= j_q + 1'b1;
          end
          if ((cmd_i.acc_mode == MODE_PICK) && (rth_q < cum_sh)) begin
            found_q <= 1'b1;
          end
        end
      end
    end
  end

  // result register
  logic             out_vld_q;
  logic [TOK_W-1:0] chosen_q;
  logic             status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.fin_en) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en) begin
      chosen_q <= empty_q ? '0 : pick_q;
      status_q <= empty_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign chosen_token_o = chosen_q;
  assign status_o       = status_q;

  assign sts_o.clr_last = clr_addr_q == ADDR_W'(VOCAB - 1);
  assign sts_o.mark_p   = p_rd_q && vocab_q;
  assign sts_o.mark_g   = g_rd_q && vocab_q;
  assign sts_o.n_zero   = n_cur == '0;
  assign sts_o.rot_last = cnt_q == CNT_W'(MAX_K - 1);
  assign sts_o.out_busy = out_vld_q && !out_ready_i;

endmodule

/* design/tts_ctrl.sv */
// ----------------------------------------------------------------------------
// tts_ctrl - sampler sequencer
// Steps clear sweep, load scaling/insert and the three draw passes.
// ----------------------------------------------------------------------------
module tts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    opcode_i,
  output logic          in_ready_o,
  input  tts_pkg::sts_t sts_i,
  output tts_pkg::cmd_t cmd_o
);
  import tts_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_SAT  = 4'd3;
  localparam logic [3:0] S_INS  = 4'd4;
  localparam logic [3:0] S_P1   = 4'd5;
  localparam logic [3:0] S_D1   = 4'd6;
  localparam logic [3:0] S_THR  = 4'd7;
  localparam logic [3:0] S_P2   = 4'd8;
  localparam logic [3:0] S_D2   = 4'd9;
  localparam logic [3:0] S_RTH  = 4'd10;
  localparam logic [3:0] S_P3   = 4'd11;
  localparam logic [3:0] S_D3   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  // scaling step: temperature, prompt penalty, generated penalty
  localparam logic [1:0] STEP_T = 2'd0;
  localparam logic [1:0] STEP_P = 2'd1;
  localparam logic [1:0] STEP_G = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       acc;

  assign in_ready_o = state_q == S_IDLE;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.acc = acc;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          case (opcode_i)
            OP_CLEAR: state_d = S_CLR;
            OP_LOAD: begin
              state_d = S_MUL;
              step_d  = STEP_T;
            end
            OP_DRAW: begin
              cmd_o.dr_start   = 1'b1;
              cmd_o.pass_start = 1'b1;
              state_d = sts_i.n_zero ? S_FIN : S_P1;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_pen = step_q != STEP_T;
        state_d = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat_en     = 1'b1;
        cmd_o.sat_drop16 = step_q != STEP_T;
        state_d = S_INS;
        if (step_q == STEP_T && sts_i.mark_p) begin
          step_d  = STEP_P;
          state_d = S_MUL;
        end else if (step_q != STEP_G && sts_i.mark_g) begin
          step_d  = STEP_G;
          state_d = S_MUL;
        end
      end
      S_INS: begin
        cmd_o.ins_en = 1'b1;
        state_d = S_IDLE;
      end
      S_P1: begin
        cmd_o.rot_en   = 1'b1;
        cmd_o.acc_mode = MODE_TOTAL;
        if (sts_i.rot_last) state_d = S_D1;
      end
      S_D1: begin
        cmd_o.acc_mode = MODE_TOTAL;
        state_d = S_THR;
      end
      S_THR: begin
        cmd_o.thr_en     = 1'b1;
        cmd_o.pass_start = 1'b1;
        state_d = S_P2;
      end
      S_P2: begin
        cmd_o.rot_en   = 1'b1;
        cmd_o.acc_mode = MODE_NUCL;
        if (sts_i.rot_last) state_d = S_D2;
      end
      S_D2: begin
        cmd_o.acc_mode = MODE_NUCL;
        state_d = S_RTH;
      end
      S_RTH: begin
        cmd_o.rth_en     = 1'b1;
        cmd_o.pass_start = 1'b1;
        state_d = S_P3;
      end
      S_P3: begin
        cmd_o.rot_en   = 1'b1;
        cmd_o.acc_mode = MODE_PICK;
        if (sts_i.rot_last) state_d = S_D3;
      end
      S_D3: begin
        cmd_o.acc_mode = MODE_PICK;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin_en = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      step_q  <= STEP_T;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

/* design/topk_topp_token_sampler.sv */
// ----------------------------------------------------------------------------
// topk_topp_token_sampler - top-k / top-p sampler with repetition penalty
// Sequencer plus datapath; one beat in per command, one beat out per draw.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time and holds in_ready_o low until
// it has finished with it. Load runs one multiply and one round/saturate
// step for the temperature and again for each mark on the token, then an
// insertion into the 64-cell candidate list. Draw walks the candidate cells
// three times (total weight, nucleus cut, pick), each walk a full rotation of
// the MAX_K cells through one registered exp-table port; a draw on an empty
// list skips the walks. Clear marks sweeps the mark memories one entry a
// cycle; the same sweep runs after reset, during which no command is taken
// but configuration writes are. Configuration writes are always accepted. A
// draw result sits in an output register, so the next command is accepted
// while it waits.
// ----------------------------------------------------------------------------
module topk_topp_token_sampler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [tts_pkg::TOK_W-1:0]      token_id_i,
  input  logic signed [tts_pkg::LOGIT_W-1:0] logit_value_i,
  input  logic [tts_pkg::FRAC_W-1:0]     random_fraction_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tts_pkg::TOK_W-1:0]      chosen_token_o,
  output logic                           status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // registers are plain flops, a write beat never stalls
  assign cfg_ready_o = 1'b1;

  tts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tts_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (opcode_i),
    .token_id_i        (token_id_i),
    .logit_value_i     (logit_value_i),
    .random_fraction_i (random_fraction_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .chosen_token_o    (chosen_token_o),
    .status_o          (status_o)
  );

endmodule
